>>> rtl/jmsi_pkg.sv
package jmsi_pkg;

  // command codes
  localparam logic [2:0] CMD_INIT      = 3'd0;
  localparam logic [2:0] CMD_TARGET    = 3'd1;
  localparam logic [2:0] CMD_VELOCITY  = 3'd2;
  localparam logic [2:0] CMD_TORQUE    = 3'd3;
  localparam logic [2:0] CMD_ABANDON   = 3'd4;
  localparam logic [2:0] CMD_STOP      = 3'd5;
  localparam logic [2:0] CMD_TICK      = 3'd6;

  // limit switch codes
  localparam logic [1:0] SW_BOTTOM     = 2'd1;
  localparam logic [1:0] SW_TOP        = 2'd2;

  // drive actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_ZERO_VEL  = 2'd1;
  localparam logic [1:0] ACT_TORQUE    = 2'd2;

  // control modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_VELOCITY = 2'd1;
  localparam logic [1:0] MODE_TORQUE   = 2'd2;
  localparam logic [1:0] MODE_POSITION = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NO_INIT   = 2'd1;
  localparam logic [1:0] ERR_BOUNDS    = 2'd2;
  localparam logic [1:0] ERR_POS_MODE  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MAX_POS   = 3'd0;
  localparam logic [2:0] REG_MIN_POS   = 3'd1;
  localparam logic [2:0] REG_BOT_POS   = 3'd2;
  localparam logic [2:0] REG_TOP_POS   = 3'd3;
  localparam logic [2:0] REG_BAND      = 3'd4;
  localparam logic [2:0] REG_VEL_LIM   = 3'd5;
  localparam logic [2:0] REG_TRQ_LIM   = 3'd6;
  localparam logic [2:0] REG_APPROACH  = 3'd7;

  localparam logic signed [32:0] LIMIT_MARGIN = 33'sd6554;

  typedef struct packed {
    logic signed [31:0] max_position;
    logic signed [31:0] min_position;
    logic signed [31:0] bottom_position;
    logic signed [31:0] top_position;
    logic [30:0]        setpoint_band;
    logic [30:0]        velocity_limit;
    logic [30:0]        torque_limit;
    logic [30:0]        approach_torque;
  } cfg_t;

  // classified command as it travels through the queue
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] arg;     // clamped setpoint, target, midpoint or snap position
    logic signed [31:0] lim_lo;  // tick: low stop bound
    logic signed [31:0] lim_hi;  // tick: high stop bound
    logic               flag;    // tick: snap estimate, target: within bounds
  } item_t;

  typedef struct packed {
    logic [1:0]         drive_action;
    logic signed [31:0] drive_torque;
    logic [1:0]         mode;
    logic [1:0]         error;
    logic signed [31:0] estimate;
    logic               ready_res;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] bound);
    logic signed [31:0] b;
    b = signed'({1'b0, bound});
    if (v > b) return b;
    if (v < -b) return -b;
    return v;
  endfunction

endpackage

>>> rtl/jmsi_if.sv
interface jmsi_cmd_if;
  import jmsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value;
  logic [1:0]         limit_switch;

  modport source (output valid, command, value, limit_switch, input ready);
  modport sink   (input valid, command, value, limit_switch, output ready);
endinterface

interface jmsi_res_if;
  import jmsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         drive_action;
  logic signed [31:0] drive_torque;
  logic [1:0]         mode;
  logic [1:0]         error;
  logic signed [31:0] estimate;
  logic               ready_res;

  modport source (output valid, drive_action, drive_torque, mode, error, estimate,
                  ready_res, input ready);
  modport sink   (input valid, drive_action, drive_torque, mode, error, estimate,
                  ready_res, output ready);
endinterface

>>> rtl/joint_motion_safety_interlock_unit.sv
// channel   | dir | beat contents
// cmd_i     | in  | command, value, limit_switch
// res_o     | out | drive_action, drive_torque, mode, error, estimate, ready_res
// cfg port  | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// one beat per cycle sustained while results are taken; a command's result is
// registered in the queue and then in the output register, which the execute
// stage writes as it pops; the execute stage carries the joint state from one beat
// to the next
// reset clears the queue, the joint state and the output valid flag and loads the
// register defaults
// a stalled result holds in the output register while the queue takes up to two
// more beats; with the queue full, ready drops until the result is taken
module joint_motion_safety_interlock_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  jmsi_cmd_if.sink           cmd_i,
  jmsi_res_if.source         res_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);
  import jmsi_pkg::*;

  cfg_t  cfg_q;
  item_t front_item;
  item_t queue_item;
  res_t  res;
  logic  queue_full;
  logic  queue_empty;
  logic  queue_pop;
  logic  res_valid;

  // register file; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_position    <= 32'sd655360;
      cfg_q.min_position    <= -32'sd655360;
      cfg_q.bottom_position <= -32'sd655360;
      cfg_q.top_position    <= 32'sd655360;
      cfg_q.setpoint_band   <= 31'd6554;
      cfg_q.velocity_limit  <= 31'd65536;
      cfg_q.torque_limit    <= 31'd65536;
      cfg_q.approach_torque <= 31'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_POS:  cfg_q.max_position    <= cfg_wdata_i;
        REG_MIN_POS:  cfg_q.min_position    <= cfg_wdata_i;
        REG_BOT_POS:  cfg_q.bottom_position <= cfg_wdata_i;
        REG_TOP_POS:  cfg_q.top_position    <= cfg_wdata_i;
        REG_BAND:     cfg_q.setpoint_band   <= cfg_wdata_i[30:0];
        REG_VEL_LIM:  cfg_q.velocity_limit  <= cfg_wdata_i[30:0];
        REG_TRQ_LIM:  cfg_q.torque_limit    <= cfg_wdata_i[30:0];
        REG_APPROACH: cfg_q.approach_torque <= cfg_wdata_i[30:0];
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  // front end: decode, clamp and precompute bounds from the registers
  jmsi_front u_front (
    .cfg_i          (cfg_q),
    .command_i      (cmd_i.command),
    .value_i        (cmd_i.value),
    .limit_switch_i (cmd_i.limit_switch),
    .item_o         (front_item)
  );

  assign cmd_i.ready = !queue_full;

  // two-entry queue decouples intake from execution
  jmsi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_i.valid && !queue_full),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_item),
    .empty_o     (queue_empty)
  );

  // back end: joint state, interlock checks and the result register
  jmsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!queue_empty),
    .item_i       (queue_item),
    .pop_o        (queue_pop),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.valid        = res_valid;
  assign res_o.drive_action = res.drive_action;
  assign res_o.drive_torque = res.drive_torque;
  assign res_o.mode         = res.mode;
  assign res_o.error        = res.error;
  assign res_o.estimate     = res.estimate;
  assign res_o.ready_res    = res.ready_res;

endmodule

>>> rtl/jmsi_front.sv
module jmsi_front (
  input  jmsi_pkg::cfg_t      cfg_i,
  input  logic [2:0]          command_i,
  input  logic signed [31:0]  value_i,
  input  logic [1:0]          limit_switch_i,
  output jmsi_pkg::item_t     item_o
);
  import jmsi_pkg::*;

  logic signed [32:0] mid_sum;

  assign mid_sum = {cfg_i.bottom_position[31], cfg_i.bottom_position}
                 + {cfg_i.top_position[31], cfg_i.top_position};

  always_comb begin
    item_o        = '0;
    item_o.cmd    = command_i;
    item_o.arg    = value_i;
    case (command_i)
      CMD_INIT: begin
        item_o.arg = mid_sum[32:1];  // floor of the midpoint
      end
      CMD_TARGET: begin
        item_o.flag   = (value_i <= cfg_i.max_position) &&
                        (value_i >= cfg_i.min_position);
      end
      CMD_VELOCITY: begin
        item_o.arg = clamp_sym(value_i, cfg_i.velocity_limit);
      end
      CMD_TORQUE, CMD_ABANDON: begin
        item_o.arg = clamp_sym(value_i, cfg_i.torque_limit);
      end
      CMD_TICK: begin
        item_o.flag   = (limit_switch_i == SW_BOTTOM) || (limit_switch_i == SW_TOP);
        item_o.arg    = (limit_switch_i == SW_BOTTOM) ? cfg_i.bottom_position
                                                      : cfg_i.top_position;
        item_o.lim_lo = sat32({cfg_i.min_position[31], cfg_i.min_position}
                              + LIMIT_MARGIN);
        item_o.lim_hi = sat32({cfg_i.max_position[31], cfg_i.max_position}
                              - LIMIT_MARGIN);
      end
      default: begin
        item_o.arg = value_i;
      end
    endcase
  end

endmodule

>>> rtl/jmsi_fifo.sv
module jmsi_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jmsi_pkg::item_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output jmsi_pkg::item_t  pop_data_o,
  output logic             empty_o
);
  import jmsi_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/jmsi_back.sv
module jmsi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jmsi_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  input  jmsi_pkg::item_t  item_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output jmsi_pkg::res_t   res_o
);
  import jmsi_pkg::*;

  logic               init_q, init_d;
  logic [1:0]         mode_q, mode_d;
  logic signed [31:0] vel_q, vel_d;
  logic signed [31:0] trq_q, trq_d;
  logic signed [31:0] est_q, est_d;
  logic signed [31:0] tgt_q, tgt_d;
  logic               out_vld_q, out_vld_d;
  res_t               out_q, out_d;

  logic signed [31:0] approach;
  logic signed [31:0] band_lo;
  logic signed [31:0] band_hi;
  logic               at_setpoint;
  logic [1:0]         tick_mode;
  logic [1:0]         act;
  logic [1:0]         err;

  assign approach    = signed'({1'b0, cfg_i.approach_torque});
  assign pop_o       = item_valid_i && (!out_vld_q || res_ready_i);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // band edges follow the current band setting around the stored target
  assign band_lo = sat32({tgt_q[31], tgt_q} - signed'({2'b00, cfg_i.setpoint_band}));
  assign band_hi = sat32({tgt_q[31], tgt_q} + signed'({2'b00, cfg_i.setpoint_band}));

  assign at_setpoint = (trq_q > 32'sd0) ? (est_q > band_lo) : (est_q < band_hi);

  always_comb begin
    init_d    = init_q;
    mode_d    = mode_q;
    vel_d     = vel_q;
    trq_d     = trq_q;
    est_d     = est_q;
    tgt_d     = tgt_q;
    act       = ACT_NONE;
    err       = ERR_OK;
    tick_mode = mode_q;

    if (!init_q && (item_i.cmd inside {CMD_TARGET, CMD_VELOCITY, CMD_TORQUE,
                                       CMD_ABANDON, CMD_TICK})) begin
      mode_d = MODE_NONE;
      act    = ACT_ZERO_VEL;
      err    = ERR_NO_INIT;
    end else begin
      case (item_i.cmd)
        CMD_INIT: begin
          est_d  = item_i.arg;
          init_d = 1'b1;
        end
        CMD_TARGET: begin
          if (!item_i.flag) begin
            tgt_d  = est_q;
            mode_d = MODE_NONE;
            act    = ACT_ZERO_VEL;
            err    = ERR_BOUNDS;
          end else begin
            tgt_d    = item_i.arg;
            trq_d    = (item_i.arg > est_q) ? approach : -approach;
            mode_d   = MODE_POSITION;
          end
        end
        CMD_VELOCITY: begin
          if (mode_q == MODE_POSITION) begin
            err = ERR_POS_MODE;
          end else begin
            vel_d  = item_i.arg;
            trq_d  = '0;
            mode_d = MODE_VELOCITY;
          end
        end
        CMD_TORQUE, CMD_ABANDON: begin
          if (item_i.cmd == CMD_TORQUE && mode_q == MODE_POSITION) begin
            err = ERR_POS_MODE;
          end else begin
            trq_d  = item_i.arg;
            vel_d  = '0;
            mode_d = MODE_TORQUE;
          end
        end
        CMD_STOP: begin
          mode_d = MODE_NONE;
          act    = ACT_ZERO_VEL;
        end
        CMD_TICK: begin
          if (mode_q == MODE_POSITION && at_setpoint) begin
            tick_mode = MODE_NONE;
          end
          if (item_i.flag) begin
            est_d = item_i.arg;
          end
          if (est_d <= item_i.lim_lo && (vel_q < 32'sd0 || trq_q < 32'sd0)) begin
            tick_mode = MODE_NONE;
          end else if (est_d >= item_i.lim_hi &&
                       (vel_q > 32'sd0 || trq_q > 32'sd0)) begin
            tick_mode = MODE_NONE;
          end
          mode_d = tick_mode;
          case (tick_mode)
            MODE_VELOCITY: act = ACT_NONE;
            MODE_NONE:     act = ACT_ZERO_VEL;
            default:       act = ACT_TORQUE;
          endcase
        end
        default: begin
          act = ACT_NONE;
        end
      endcase
    end

    out_d.drive_action = act;
    out_d.drive_torque = (act == ACT_TORQUE) ? trq_d : '0;
    out_d.mode         = mode_d;
    out_d.error        = err;
    out_d.estimate     = est_d;
    out_d.ready_res    = init_d;

    out_vld_d = pop_o ? 1'b1 : (res_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b0;
      mode_q    <= MODE_NONE;
      vel_q     <= '0;
      trq_q     <= '0;
      est_q     <= '0;
      tgt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop_o) begin
        init_q   <= init_d;
        mode_q   <= mode_d;
        vel_q    <= vel_d;
        trq_q    <= trq_d;
        est_q    <= est_d;
        tgt_q    <= tgt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

>>> tb/tb_joint_motion_safety_interlock_unit.sv
`timescale 1ns / 100ps

module tb_joint_motion_safety_interlock_unit;
  import jmsi_pkg::*;

  // codes the package has no name for
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;   // spare command code, ignored by the joint
  localparam logic [1:0] SW_TRANSIT  = 2'd0;
  localparam logic [1:0] SW_SPARE    = 2'd3;   // behaves as in transit

  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLDOFF_CYCLES  = 150;
  localparam int IDLE_LIMIT      = 2000;       // cycles with no beat on either side
  localparam int SETTLE_CYCLES   = 4;          // quiet time after the last expected result comes home

  typedef enum {CFG_DEFAULT, CFG_TYPICAL, CFG_HIGH, CFG_LOW, CFG_WILD} cfg_flavour_e;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] val;
    logic [1:0]         sw;
    bit                 fixed;   // expectation typed into the table
    res_t               res;
  } stim_row_t;

  typedef struct {
    bit   fixed;
    res_t res;
  } row_expect_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  jmsi_cmd_if cmd_if ();
  jmsi_res_if res_if ();

  joint_motion_safety_interlock_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // joint state as the predictor sees it
  cfg_t               jcfg;
  logic               jt_ready;
  logic [1:0]         jt_mode;
  logic signed [31:0] jt_target;
  logic signed [31:0] jt_velocity;
  logic signed [31:0] jt_torque;
  logic signed [31:0] jt_est;

  row_expect_t row_expect_q [$];     // one per beat offered, in order
  res_t        pending_results [$];  // expected result beats not yet seen
  stim_row_t   directed_rows [$];
  logic [31:0] cfg_words [8];

  int  failures;
  int  results_checked;
  int  beats_sent;
  int  idle_cycles;
  int  burst_left;
  int  holdoffs_done;
  int  phases_run;
  bit  holdoff_req;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] saturate_q16(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_to_bound(input logic signed [31:0] v,
                                                        input logic [30:0] bound);
    longint b;
    b = longint'(bound);
    if (v > b) return b[31:0];
    if (v < -b) return 32'(-b);
    return v;
  endfunction

  // one command in, one result out; updates the joint state in place
  function automatic res_t predict_joint_response(input logic [2:0] cmd,
                                                  input logic signed [31:0] val,
                                                  input logic [1:0] sw);
    res_t               r;
    logic [1:0]         act;
    logic [1:0]         err;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] approach;
    longint             mid;
    bit                 reached;
    act = ACT_NONE;
    err = ERR_OK;
    approach = $signed({1'b0, jcfg.approach_torque});
    if (!jt_ready && (cmd == CMD_TARGET || cmd == CMD_VELOCITY || cmd == CMD_TORQUE ||
                      cmd == CMD_ABANDON || cmd == CMD_TICK)) begin
      jt_mode = MODE_NONE;
      act = ACT_ZERO_VEL;
      err = ERR_NO_INIT;
    end else if (cmd == CMD_INIT) begin
      // floor of the midpoint, taken at 64 bits so the sum cannot wrap
      mid = longint'(jcfg.bottom_position) + longint'(jcfg.top_position);
      jt_est = 32'(mid >>> 1);
      jt_ready = 1'b1;
    end else if (cmd == CMD_TARGET) begin
      if (val > jcfg.max_position || val < jcfg.min_position) begin
        jt_target = jt_est;
        jt_mode = MODE_NONE;
        act = ACT_ZERO_VEL;
        err = ERR_BOUNDS;
      end else begin
        jt_target = val;
        jt_torque = (val > jt_est) ? approach : -approach;
        jt_mode = MODE_POSITION;
      end
    end else if (cmd == CMD_VELOCITY) begin
      if (jt_mode == MODE_POSITION) begin
        err = ERR_POS_MODE;
      end else begin
        jt_velocity = clamp_to_bound(val, jcfg.velocity_limit);
        jt_torque = '0;
        jt_mode = MODE_VELOCITY;
      end
    end else if (cmd == CMD_TORQUE || cmd == CMD_ABANDON) begin
      if (cmd == CMD_TORQUE && jt_mode == MODE_POSITION) begin
        err = ERR_POS_MODE;
      end else begin
        jt_torque = clamp_to_bound(val, jcfg.torque_limit);
        jt_velocity = '0;
        jt_mode = MODE_TORQUE;
      end
    end else if (cmd == CMD_STOP) begin
      jt_mode = MODE_NONE;
      act = ACT_ZERO_VEL;
    end else if (cmd == CMD_TICK) begin
      lo = saturate_q16(longint'(jcfg.min_position) + longint'(LIMIT_MARGIN));
      hi = saturate_q16(longint'(jcfg.max_position) - longint'(LIMIT_MARGIN));
      // band test uses the estimate from before any snap
      if (jt_torque > 0)
        reached = jt_est > saturate_q16(longint'(jt_target) - longint'(jcfg.setpoint_band));
      else
        reached = jt_est < saturate_q16(longint'(jt_target) + longint'(jcfg.setpoint_band));
      if (jt_mode == MODE_POSITION && reached) jt_mode = MODE_NONE;
      if (sw == SW_BOTTOM) jt_est = jcfg.bottom_position;
      else if (sw == SW_TOP) jt_est = jcfg.top_position;
      if (jt_est <= lo && (jt_velocity < 0 || jt_torque < 0)) jt_mode = MODE_NONE;
      else if (jt_est >= hi && (jt_velocity > 0 || jt_torque > 0)) jt_mode = MODE_NONE;
      if (jt_mode == MODE_VELOCITY) act = ACT_NONE;
      else if (jt_mode == MODE_NONE) act = ACT_ZERO_VEL;
      else act = ACT_TORQUE;
    end
    r.drive_action = act;
    r.drive_torque = (act == ACT_TORQUE) ? jt_torque : '0;
    r.mode         = jt_mode;
    r.error        = err;
    r.estimate     = jt_est;
    r.ready_res    = jt_ready;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint pick_between(input longint lo, input longint hi);
    longint unsigned raw;
    if (hi <= lo) return lo;
    raw = {$urandom, $urandom};
    return lo + longint'(raw % longint'(hi - lo + 1));
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic signed [31:0] val,
                         input logic [1:0] sw, input bit fixed = 1'b0,
                         input res_t res = '0);
    stim_row_t row;
    row.cmd = cmd;
    row.val = val;
    row.sw = sw;
    row.fixed = fixed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // offer one beat and hold it until the block takes it
  task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] val,
                              input logic [1:0] sw, input bit fixed, input res_t res);
    row_expect_t e;
    e.fixed = fixed;
    e.res = res;
    row_expect_q.push_back(e);
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= cmd;
    cmd_if.value        <= val;
    cmd_if.limit_switch <= sw;
    do @(posedge clk); while (!cmd_if.ready);
    beats_sent++;
  endtask

  // bursts of back-to-back beats with idle gaps between; no gaps during a hold-off
  task automatic pace_sender;
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = holdoff_req ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender goes quiet until every expected result has come back
  task automatic drain_results;
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_config(input cfg_flavour_e flavour);
    longint lo_pos;
    longint hi_pos;
    longint tmp;
    case (flavour)
      CFG_DEFAULT: begin
        cfg_words[REG_MAX_POS]  = 32'd655360;
        cfg_words[REG_MIN_POS]  = -32'sd655360;
        cfg_words[REG_BOT_POS]  = -32'sd655360;
        cfg_words[REG_TOP_POS]  = 32'd655360;
        cfg_words[REG_BAND]     = 32'd6554;
        cfg_words[REG_VEL_LIM]  = 32'd65536;
        cfg_words[REG_TRQ_LIM]  = 32'd65536;
        cfg_words[REG_APPROACH] = 32'd32768;
      end
      CFG_HIGH: begin
        // all-ones on the narrow registers checks that the top bit is dropped
        for (int i = REG_MAX_POS; i <= REG_TOP_POS; i++) cfg_words[i] = 32'h7FFF_FFFF;
        for (int i = REG_BAND; i <= REG_APPROACH; i++) cfg_words[i] = 32'hFFFF_FFFF;
      end
      CFG_LOW: begin
        for (int i = REG_MAX_POS; i <= REG_TOP_POS; i++) cfg_words[i] = 32'h8000_0000;
        for (int i = REG_BAND; i <= REG_APPROACH; i++) cfg_words[i] = 32'h8000_0000;
      end
      CFG_WILD: begin
        for (int i = REG_MAX_POS; i <= REG_APPROACH; i++) cfg_words[i] = $urandom;
      end
      default: begin
        // a travel of a few tens of units with switch positions near the ends
        lo_pos = -(longint'($urandom_range(1, 40)) <<< 16);
        hi_pos = longint'($urandom_range(1, 40)) <<< 16;
        if ($urandom_range(0, 7) == 0) begin
          tmp = lo_pos;
          lo_pos = hi_pos;
          hi_pos = tmp;
        end
        cfg_words[REG_MIN_POS]  = 32'(lo_pos);
        cfg_words[REG_MAX_POS]  = 32'(hi_pos);
        cfg_words[REG_BOT_POS]  = 32'(lo_pos + pick_between(-8192, 16384));
        cfg_words[REG_TOP_POS]  = 32'(hi_pos + pick_between(-16384, 8192));
        cfg_words[REG_BAND]     = $urandom_range(0, 'h20000);
        cfg_words[REG_VEL_LIM]  = $urandom_range(0, 'h40000);
        cfg_words[REG_TRQ_LIM]  = $urandom_range(0, 'h40000);
        cfg_words[REG_APPROACH] = $urandom_range(0, 'h20000);
        for (int i = REG_BAND; i <= REG_APPROACH; i++)
          cfg_words[i][31] = $urandom_range(0, 1);
      end
    endcase
  endtask

  // write every register back to back, then mirror them into the predictor
  task automatic load_config;
    for (int i = REG_MAX_POS; i <= REG_APPROACH; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= cfg_words[i];
      @(posedge clk);
    end
    cfg_we_i <= 1'b0;
    jcfg.max_position    = cfg_words[REG_MAX_POS];
    jcfg.min_position    = cfg_words[REG_MIN_POS];
    jcfg.bottom_position = cfg_words[REG_BOT_POS];
    jcfg.top_position    = cfg_words[REG_TOP_POS];
    jcfg.setpoint_band   = cfg_words[REG_BAND][30:0];
    jcfg.velocity_limit  = cfg_words[REG_VEL_LIM][30:0];
    jcfg.torque_limit    = cfg_words[REG_TRQ_LIM][30:0];
    jcfg.approach_torque = cfg_words[REG_APPROACH][30:0];
  endtask

  // mostly sensible command streams, shaped by the current limits and estimate
  task automatic make_random_command(output logic [2:0] cmd,
                                     output logic signed [31:0] val,
                                     output logic [1:0] sw);
    int     pick;
    longint lim;
    longint reach;
    pick = $urandom_range(0, 99);
    val = $urandom;
    sw = $urandom_range(0, 3);
    if (pick < 4) cmd = CMD_INIT;
    else if (pick < 20) cmd = CMD_TARGET;
    else if (pick < 32) cmd = CMD_VELOCITY;
    else if (pick < 44) cmd = CMD_TORQUE;
    else if (pick < 50) cmd = CMD_ABANDON;
    else if (pick < 55) cmd = CMD_STOP;
    else if (pick < 98) cmd = CMD_TICK;
    else cmd = CMD_UNKNOWN;

    if (cmd == CMD_TICK) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) sw = SW_TRANSIT;
      else if (pick < 80) sw = SW_BOTTOM;
      else if (pick < 92) sw = SW_TOP;
      else sw = SW_SPARE;
    end else if (cmd == CMD_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 1) begin
        case ($urandom_range(0, 3))
          0: val = jcfg.max_position;
          1: val = jcfg.min_position;
          2: val = jcfg.max_position + 32'sd1;
          default: val = jcfg.min_position - 32'sd1;
        endcase
      end else if (pick >= 2 && pick <= 4) begin
        // close to the estimate so the band test decides on the next tick
        reach = 2 * longint'(jcfg.setpoint_band) + 1;
        val = saturate_q16(longint'(jt_est) + pick_between(-reach, reach));
      end else if (pick > 4 && jcfg.min_position <= jcfg.max_position) begin
        val = 32'(pick_between(longint'(jcfg.min_position), longint'(jcfg.max_position)));
      end
    end else if (cmd == CMD_VELOCITY || cmd == CMD_TORQUE || cmd == CMD_ABANDON) begin
      lim = (cmd == CMD_VELOCITY) ? longint'(jcfg.velocity_limit)
                                  : longint'(jcfg.torque_limit);
      pick = $urandom_range(0, 9);
      if (pick == 1)
        val = saturate_q16(($urandom_range(0, 1) ? lim : -lim) + pick_between(-2, 2));
      else if (pick > 1)
        val = saturate_q16(pick_between(-2 * lim - 1, 2 * lim + 1));
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // beat monitor: predicts on every command beat, checks every result beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : beat_monitor
    row_expect_t e;
    res_t        predicted;
    res_t        want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cmd_if.valid && cmd_if.ready) begin
        moved = 1'b1;
        e = row_expect_q.pop_front();
        // the predictor runs on every beat so its state stays in step
        predicted = predict_joint_response(cmd_if.command, cmd_if.value, cmd_if.limit_switch);
        pending_results.push_back(e.fixed ? e.res : predicted);
      end
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual action %0d mode %0d",
                   $time, res_if.drive_action, res_if.mode);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("drive_action", want.drive_action, res_if.drive_action);
          check_field("drive_torque", want.drive_torque, res_if.drive_torque);
          check_field("mode",         want.mode,         res_if.mode);
          check_field("error",        want.error,        res_if.error);
          check_field("estimate",     want.estimate,     res_if.estimate);
          check_field("ready_res",    want.ready_res,    res_if.ready_res);
          results_checked++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // nothing moving on either side for too long means the block has hung
  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_joint_motion_safety_interlock_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result sink: runs of steady ready, coin-flip ready and a fixed stall pattern,
  // plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int style;
    int span;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (holdoff_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
        holdoffs_done++;
      end else begin
        style = $urandom_range(0, 2);
        span = $urandom_range(5, 60);
        for (int k = 0; k < span && !holdoff_req; k++) begin
          case (style)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= $urandom_range(0, 1);
            default: res_if.ready <= (k % 4) != 3;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    cfg_flavour_e       phase_plan [9];
    logic [2:0]         c;
    logic signed [31:0] v;
    logic [1:0]         s;

    phase_plan = '{CFG_DEFAULT, CFG_TYPICAL, CFG_HIGH, CFG_TYPICAL, CFG_LOW,
                   CFG_WILD, CFG_TYPICAL, CFG_WILD, CFG_DEFAULT};

    // every input known from the first step
    rst_ni              <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CMD_STOP;
    cmd_if.value        <= '0;
    cmd_if.limit_switch <= SW_TRANSIT;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_MAX_POS;
    cfg_wdata_i         <= '0;

    // predictor comes out of reset with the register defaults
    jcfg.max_position    = 32'sd655360;
    jcfg.min_position    = -32'sd655360;
    jcfg.bottom_position = -32'sd655360;
    jcfg.top_position    = 32'sd655360;
    jcfg.setpoint_band   = 31'd6554;
    jcfg.velocity_limit  = 31'd65536;
    jcfg.torque_limit    = 31'd65536;
    jcfg.approach_torque = 31'd32768;
    jt_ready    = 1'b0;
    jt_mode     = MODE_NONE;
    jt_target   = '0;
    jt_velocity = '0;
    jt_torque   = '0;
    jt_est      = '0;
    holdoff_req = 1'b0;
    burst_left  = 0;

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed table on the reset settings; fixed rows carry their own answer
    // stop is allowed before init, every motion command and tick is refused
    add_row(CMD_STOP, 32'sd0, SW_TRANSIT, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_OK, 32'sd0, 1'b0});
    add_row(CMD_TARGET, 32'sd0, SW_TRANSIT, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_NO_INIT, 32'sd0, 1'b0});
    add_row(CMD_VELOCITY, 32'sd100, SW_TOP, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_NO_INIT, 32'sd0, 1'b0});
    add_row(CMD_TORQUE, -32'sd100, SW_SPARE, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_NO_INIT, 32'sd0, 1'b0});
    add_row(CMD_ABANDON, 32'sd5, SW_TRANSIT, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_NO_INIT, 32'sd0, 1'b0});
    add_row(CMD_TICK, 32'sd0, SW_BOTTOM, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_NO_INIT, 32'sd0, 1'b0});
    // the spare command code leaves everything alone
    add_row(CMD_UNKNOWN, 32'h7FFF_FFFF, SW_SPARE, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_NONE, ERR_OK, 32'sd0, 1'b0});
    // init puts the estimate at the switch midpoint
    add_row(CMD_INIT, 32'sd0, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_NONE, ERR_OK, 32'sd0, 1'b1});
    // targets one step outside either bound
    add_row(CMD_TARGET, 32'sd655361, SW_TRANSIT, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_BOUNDS, 32'sd0, 1'b1});
    add_row(CMD_TARGET, -32'sd655361, SW_TRANSIT, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_BOUNDS, 32'sd0, 1'b1});
    // full-scale velocity clamps to the limit; tick in velocity mode sends nothing
    add_row(CMD_VELOCITY, 32'h7FFF_FFFF, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_VELOCITY, ERR_OK, 32'sd0, 1'b1});
    add_row(CMD_TICK, 32'sd0, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_VELOCITY, ERR_OK, 32'sd0, 1'b1});
    add_row(CMD_VELOCITY, 32'h8000_0000, SW_TRANSIT);
    add_row(CMD_TORQUE, 32'h7FFF_FFFF, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_TORQUE, ERR_OK, 32'sd0, 1'b1});
    add_row(CMD_TICK, 32'sd0, SW_TRANSIT, 1,
            res_t'{ACT_TORQUE, 32'sd65536, MODE_TORQUE, ERR_OK, 32'sd0, 1'b1});
    // top switch snaps the estimate and stops the upward push
    add_row(CMD_TICK, 32'sd0, SW_TOP, 1,
            res_t'{ACT_ZERO_VEL, 32'sd0, MODE_NONE, ERR_OK, 32'sd655360, 1'b1});
    // downward push into the bottom switch
    add_row(CMD_TORQUE, -32'sd100, SW_TRANSIT);
    add_row(CMD_TICK, 32'sd0, SW_BOTTOM);
    // position move to the top bound, then commands refused in position mode
    add_row(CMD_TARGET, 32'sd655360, SW_TRANSIT);
    add_row(CMD_VELOCITY, 32'sd5, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_POSITION, ERR_POS_MODE, -32'sd655360, 1'b1});
    add_row(CMD_TICK, 32'sd0, SW_SPARE);
    add_row(CMD_TICK, 32'sd0, SW_TOP);
    add_row(CMD_TARGET, -32'sd655360, SW_TRANSIT);
    add_row(CMD_TORQUE, 32'sd5, SW_TRANSIT, 1,
            res_t'{ACT_NONE, 32'sd0, MODE_POSITION, ERR_POS_MODE, 32'sd655360, 1'b1});
    // abandon is taken even while a position move is under way
    add_row(CMD_ABANDON, 32'h8000_0000, SW_TRANSIT);
    add_row(CMD_TICK, 32'sd0, SW_TRANSIT);
    add_row(CMD_STOP, 32'sd0, SW_BOTTOM);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].sw,
                   directed_rows[i].fixed, directed_rows[i].res);
      pace_sender();
    end

    // random phases, each on its own register setting
    foreach (phase_plan[p]) begin
      drain_results();
      pick_config(phase_plan[p]);
      load_config();
      phases_run++;
      // long result stall while the sender keeps pushing, so the input backs up
      if (p == 1) holdoff_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // one pause in mid-phase until every result is home
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain_results();
        make_random_command(c, v, s);
        send_command(c, v, s, 1'b0, '0);
        pace_sender();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d command beats over %0d register settings, %0d results checked",
             beats_sent, phases_run, results_checked);
    $display("long result hold-offs: %0d, mismatches: %0d", holdoffs_done, failures);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb_joint_motion_safety_interlock_unit: PASS");
    end else begin
      $display("tb_joint_motion_safety_interlock_unit: FAIL");
    end
    $finish;
  end

endmodule
